// File: rtl/nsc_pkg.sv
// Shared constants, types and codes for the nearest segment collision block.
// Used by nsc_div and nearest_segment_collision.
package nsc_pkg;

    localparam int SEGMENT_SLOTS = 256;
    localparam int SHAPE_SLOTS   = 64;
    localparam int COORD_BITS    = 24;

    localparam int SEG_W     = 8;                      // entry_index port width
    localparam int SHP_W     = 6;                      // shape_index port width
    localparam int SEG_IDX_W = $clog2(SEGMENT_SLOTS);
    localparam int SHP_IDX_W = $clog2(SHAPE_SLOTS);

    localparam int DIFF_W = COORD_BITS + 1;            // coordinate differences
    localparam int MUL_W  = DIFF_W + 1;                // signed multiplier operand
    localparam int PROD_W = 2 * MUL_W;
    localparam int RAW_W  = 2 * DIFF_W + 1;            // den, sn, tn before normalizing
    localparam int PART_W = DIFF_W;
    localparam int MAG_W  = 2 * PART_W;                // |den|, |tn|
    localparam int ACC_W  = 2 * MAG_W + 4;
    localparam int NUM_W  = MAG_W + DIFF_W + 2;        // |src*den + tn*d|

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_FLAGS = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic [SHP_IDX_W-1:0]         owner;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
    } seg_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_DIFF,
        S_MUL,
        S_CHK,
        S_CMP,
        S_CMPD,
        S_FIN,
        S_NMUL,
        S_DIVS,
        S_DIV,
        S_DONE
    } state_t;

endpackage

// File: rtl/nsc_div.sv
// Restoring divider, one quotient bit per cycle, for the hit point.
// Depends on nsc_pkg.
module nsc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [nsc_pkg::NUM_W-1:0] num,
    input  logic [nsc_pkg::MAG_W-1:0] den,
    output logic                      done,
    output logic [nsc_pkg::NUM_W-1:0] quo
);
    import nsc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [MAG_W-1:0] rem_reg;
    logic [MAG_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [MAG_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            // remainder stays below den, so MAG_W bits hold it
            rem_reg <= fits ? MAG_W'(trial - {1'b0, den_reg}) : trial[MAG_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/nearest_segment_collision.sv
// Nearest segment collision: segment table in a synchronous RAM, query engine.
// A load or flag request goes straight to S_DONE, which registers a no-hit result.
// A query scans every slot: a free slot is skipped, a disabled owner is dropped after
// the read, and a candidate is multiplied out, checked and compared with any current
// best; a hit adds the two hit-point divisions (one quotient bit a cycle).
// One request in work at a time. Reset: all slots free, shapes enabled and two-way.
module nearest_segment_collision (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     command,
    input  logic [nsc_pkg::SEG_W-1:0]      entry_index,
    input  logic [nsc_pkg::SHP_W-1:0]      shape_index,
    input  logic signed [nsc_pkg::COORD_BITS-1:0] ax,
    input  logic signed [nsc_pkg::COORD_BITS-1:0] ay,
    input  logic signed [nsc_pkg::COORD_BITS-1:0] bx,
    input  logic signed [nsc_pkg::COORD_BITS-1:0] by,
    input  logic                           entry_valid,
    input  logic                           one_way,
    input  logic                           enabled,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    output logic signed [nsc_pkg::COORD_BITS-1:0] hit_x,
    output logic signed [nsc_pkg::COORD_BITS-1:0] hit_y,
    output logic [nsc_pkg::SEG_W-1:0]      surface_index,
    output logic [nsc_pkg::SHP_W-1:0]      hit_shape
);
    import nsc_pkg::*;

    state_t state_reg, state_next;

    seg_entry_t seg_mem [SEGMENT_SLOTS];
    seg_entry_t rd_reg;
    logic [SEGMENT_SLOTS-1:0] in_use_reg;
    logic [SHAPE_SLOTS-1:0]   one_way_reg;
    logic [SHAPE_SLOTS-1:0]   enabled_reg;

    logic accept;
    logic mem_we;
    logic rd_en;
    logic advance;
    logic last_slot;
    logic out_free;

    logic signed [COORD_BITS-1:0] ax_reg, ay_reg;
    logic signed [DIFF_W-1:0]     d1x_reg, d1y_reg;
    logic signed [DIFF_W-1:0]     d2x_reg, d2y_reg, wx_reg, wy_reg;
    logic                         ow_reg;
    logic [SEG_IDX_W-1:0]         idx_reg;
    logic [2:0]                   step_reg;

    logic signed [MUL_W-1:0]  ma, mb, mc, md;
    logic signed [PROD_W-1:0] pa_reg, pb_reg;
    logic signed [PROD_W:0]   pdiff, psum;
    logic signed [RAW_W-1:0]  den_raw_reg, sn_raw_reg, tn_raw_reg;
    logic signed [RAW_W-1:0]  den_n, sn_n, tn_n;
    logic                     cand_ok;

    logic [MAG_W-1:0]     cand_t_reg, cand_den_reg, best_t_reg, best_den_reg;
    logic [SEG_IDX_W-1:0] best_slot_reg;
    logic [SHP_IDX_W-1:0] best_owner_reg;
    logic                 found_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_term;
    logic [5:0]              shamt;
    logic [ACC_W-1:0]        acc_mag;
    logic                    axis_reg;
    logic                    neg_reg;

    logic                    div_start;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quo;
    logic [COORD_BITS-1:0]   coord_q;

    logic                    res_hit_reg;
    logic [COORD_BITS-1:0]   res_x_reg, res_y_reg;
    logic [SEG_W-1:0]        res_slot_reg;
    logic [SHP_W-1:0]        res_shape_reg;

    logic                    out_valid_reg;
    logic                    hit_reg;
    logic [COORD_BITS-1:0]   hit_x_reg, hit_y_reg;
    logic [SEG_W-1:0]        surface_index_reg;
    logic [SHP_W-1:0]        hit_shape_reg;

    assign accept    = in_valid && in_ready;
    assign mem_we    = accept && (command == CMD_LOAD)
                       && ({1'b0, entry_index} < (SEG_W+1)'(SEGMENT_SLOTS))
                       && ({1'b0, shape_index} < (SHP_W+1)'(SHAPE_SLOTS));
    assign last_slot = idx_reg == SEG_IDX_W'(SEGMENT_SLOTS - 1);
    assign out_free  = !out_valid_reg || out_ready;

    // Segment RAM: written by loads, read one slot per scan step.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seg_mem[entry_index[SEG_IDX_W-1:0]] <= '{owner: shape_index[SHP_IDX_W-1:0],
                                                    sx: ax, sy: ay, ex: bx, ey: by};
        end
        if (rd_en)
        begin
            rd_reg <= seg_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= '0;
            one_way_reg <= '0;
            enabled_reg <= '1;
        end
        else
        begin
            if (mem_we)
            begin
                in_use_reg[entry_index[SEG_IDX_W-1:0]] <= entry_valid;
            end
            if (accept && (command == CMD_FLAGS)
                && ({1'b0, shape_index} < (SHP_W+1)'(SHAPE_SLOTS)))
            begin
                one_way_reg[shape_index[SHP_IDX_W-1:0]] <= one_way;
                enabled_reg[shape_index[SHP_IDX_W-1:0]] <= enabled;
            end
        end
    end

    // Multiplier operand selection
    always_comb
    begin
        ma = '0;
        mb = '0;
        mc = '0;
        md = '0;
        shamt = '0;
        case (state_reg)
            S_MUL:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        ma = MUL_W'(d1x_reg); mb = MUL_W'(d2y_reg);
                        mc = MUL_W'(d1y_reg); md = MUL_W'(d2x_reg);
                    end
                    3'd1:
                    begin
                        ma = MUL_W'(d1x_reg); mb = MUL_W'(wy_reg);
                        mc = MUL_W'(d1y_reg); md = MUL_W'(wx_reg);
                    end
                    default:
                    begin
                        ma = MUL_W'(d2x_reg); mb = MUL_W'(wy_reg);
                        mc = MUL_W'(d2y_reg); md = MUL_W'(wx_reg);
                    end
                endcase
            end
            S_CMP:
            begin
                // cand_t*best_den - best_t*cand_den in 25-bit partials
                ma = step_reg[1] ? {1'b0, cand_t_reg[MAG_W-1:PART_W]}
                                 : {1'b0, cand_t_reg[PART_W-1:0]};
                mc = step_reg[1] ? {1'b0, best_t_reg[MAG_W-1:PART_W]}
                                 : {1'b0, best_t_reg[PART_W-1:0]};
                mb = step_reg[0] ? {1'b0, best_den_reg[MAG_W-1:PART_W]}
                                 : {1'b0, best_den_reg[PART_W-1:0]};
                md = step_reg[0] ? {1'b0, cand_den_reg[MAG_W-1:PART_W]}
                                 : {1'b0, cand_den_reg[PART_W-1:0]};
                case (step_reg)
                    3'd1:    shamt = 6'd0;
                    3'd2:    shamt = 6'(PART_W);
                    3'd3:    shamt = 6'(PART_W);
                    default: shamt = 6'(2 * PART_W);
                endcase
            end
            S_NMUL:
            begin
                // src*den + tn*d
                ma = MUL_W'(axis_reg ? ay_reg : ax_reg);
                mb = step_reg[0] ? {1'b0, best_den_reg[MAG_W-1:PART_W]}
                                 : {1'b0, best_den_reg[PART_W-1:0]};
                mc = step_reg[0] ? {1'b0, best_t_reg[MAG_W-1:PART_W]}
                                 : {1'b0, best_t_reg[PART_W-1:0]};
                md = MUL_W'(axis_reg ? d1y_reg : d1x_reg);
                shamt = (step_reg == 3'd2) ? 6'(PART_W) : 6'd0;
            end
            default:
            begin
                ma = '0;
            end
        endcase
    end

    assign pdiff    = (PROD_W+1)'(pa_reg) - (PROD_W+1)'(pb_reg);
    assign psum     = (PROD_W+1)'(pa_reg) + (PROD_W+1)'(pb_reg);
    assign acc_term = (state_reg == S_NMUL) ? (ACC_W'(psum) <<< shamt)
                                            : (ACC_W'(pdiff) <<< shamt);

    // Sign normalization and range checks of one candidate
    always_comb
    begin
        den_n = den_raw_reg[RAW_W-1] ? -den_raw_reg : den_raw_reg;
        sn_n  = den_raw_reg[RAW_W-1] ? -sn_raw_reg  : sn_raw_reg;
        tn_n  = den_raw_reg[RAW_W-1] ? -tn_raw_reg  : tn_raw_reg;
        // one-way cross product is -sn before normalizing
        cand_ok = (den_n != '0) && !sn_n[RAW_W-1] && (sn_n <= den_n)
                  && !tn_n[RAW_W-1] && (tn_n <= den_n)
                  && !(ow_reg && !sn_raw_reg[RAW_W-1] && (sn_raw_reg != '0));
    end

    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign coord_q = neg_reg ? COORD_BITS'(-div_quo[COORD_BITS-1:0])
                             : div_quo[COORD_BITS-1:0];

    nsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_mag[NUM_W-1:0]),
        .den   (best_den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        rd_en      = 1'b0;
        advance    = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = (command == CMD_QUERY) ? S_RD : S_DONE;
                end
            end
            S_RD:
            begin
                if (in_use_reg[idx_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = S_DIFF;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_DIFF:
            begin
                if (enabled_reg[rd_reg.owner])
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_MUL:
            begin
                if (step_reg == 3'd3)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (cand_ok && found_reg)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_CMP:
            begin
                if (step_reg == 3'd4)
                begin
                    state_next = S_CMPD;
                end
            end
            S_CMPD:
            begin
                advance = 1'b1;
            end
            S_FIN:
            begin
                state_next = found_reg ? S_NMUL : S_DONE;
            end
            S_NMUL:
            begin
                if (step_reg == 3'd2)
                begin
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = axis_reg ? S_DONE : S_NMUL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (advance)
        begin
            state_next = last_slot ? S_FIN : S_RD;
        end
    end

    // Query datapath
    always_ff @(posedge clk)
    begin
        pa_reg <= ma * mb;
        pb_reg <= mc * md;
        if (accept)
        begin
            ax_reg  <= ax;
            ay_reg  <= ay;
            d1x_reg <= DIFF_W'(bx) - DIFF_W'(ax);
            d1y_reg <= DIFF_W'(by) - DIFF_W'(ay);
            idx_reg <= '0;
        end
        if (advance)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        case (state_reg)
            S_DIFF:
            begin
                d2x_reg  <= DIFF_W'(rd_reg.ex) - DIFF_W'(rd_reg.sx);
                d2y_reg  <= DIFF_W'(rd_reg.ey) - DIFF_W'(rd_reg.sy);
                wx_reg   <= DIFF_W'(ax_reg) - DIFF_W'(rd_reg.sx);
                wy_reg   <= DIFF_W'(ay_reg) - DIFF_W'(rd_reg.sy);
                ow_reg   <= one_way_reg[rd_reg.owner];
                step_reg <= '0;
            end
            S_MUL:
            begin
                step_reg <= step_reg + 1'b1;
                case (step_reg)
                    3'd1:    den_raw_reg <= pdiff[RAW_W-1:0];
                    3'd2:    sn_raw_reg  <= pdiff[RAW_W-1:0];
                    3'd3:    tn_raw_reg  <= pdiff[RAW_W-1:0];
                    default: step_reg    <= 3'd1;
                endcase
            end
            S_CHK:
            begin
                cand_t_reg   <= tn_n[MAG_W-1:0];
                cand_den_reg <= den_n[MAG_W-1:0];
                step_reg     <= '0;
            end
            S_CMP, S_NMUL:
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 3'd0)
                begin
                    acc_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_reg + acc_term;
                end
            end
            S_FIN:
            begin
                axis_reg <= 1'b0;
                step_reg <= '0;
            end
            S_DIVS:
            begin
                neg_reg <= acc_reg[ACC_W-1];
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    step_reg <= '0;
                    axis_reg <= 1'b1;
                end
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

    // Best candidate tracking; later slots win ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (accept)
        begin
            found_reg <= 1'b0;
        end
        else if ((state_reg == S_CHK && cand_ok && !found_reg)
                 || (state_reg == S_CMPD && (acc_reg[ACC_W-1] || acc_reg == '0)))
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHK && cand_ok && !found_reg)
        begin
            best_t_reg     <= tn_n[MAG_W-1:0];
            best_den_reg   <= den_n[MAG_W-1:0];
            best_slot_reg  <= idx_reg;
            best_owner_reg <= rd_reg.owner;
        end
        else if (state_reg == S_CMPD && (acc_reg[ACC_W-1] || acc_reg == '0))
        begin
            best_t_reg     <= cand_t_reg;
            best_den_reg   <= cand_den_reg;
            best_slot_reg  <= idx_reg;
            best_owner_reg <= rd_reg.owner;
        end
    end

    // Result assembly
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_hit_reg   <= 1'b0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
            res_slot_reg  <= '0;
            res_shape_reg <= '0;
        end
        else if (state_reg == S_FIN && found_reg)
        begin
            res_hit_reg   <= 1'b1;
            res_slot_reg  <= SEG_W'(best_slot_reg);
            res_shape_reg <= SHP_W'(best_owner_reg);
        end
        else if (state_reg == S_DIV && div_done)
        begin
            if (axis_reg)
            begin
                res_y_reg <= coord_q;
            end
            else
            begin
                res_x_reg <= coord_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            hit_reg           <= res_hit_reg;
            hit_x_reg         <= res_x_reg;
            hit_y_reg         <= res_y_reg;
            surface_index_reg <= res_slot_reg;
            hit_shape_reg     <= res_shape_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign hit_x         = hit_x_reg;
    assign hit_y         = hit_y_reg;
    assign surface_index = surface_index_reg;
    assign hit_shape     = hit_shape_reg;

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide step");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_x == '0 && hit_y == '0
                              && surface_index == '0 && hit_shape == '0)
        else $error("miss result carries nonzero fields");

    a_best_den: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && state_reg != S_IDLE && state_reg != S_DONE |-> best_den_reg != '0)
        else $error("best candidate has zero denominator");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted request left engine idle");

endmodule
